>>> hdl/krt_pkg.sv
// Shared types, constants and command codes for the keyed record table.
package krt_pkg;

   localparam int Capacity = 64;
   localparam int IdxW = $clog2(Capacity);
   localparam int CntW = $clog2(Capacity + 1);

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_NOT_FOUND = 3'd1;
   localparam logic [2:0] ST_DUPLICATE = 3'd2;
   localparam logic [2:0] ST_FULL = 3'd3;
   localparam logic [2:0] ST_EMPTY = 3'd4;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_LOOKUP = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_DUMP   = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [31:0] key;
      logic [7:0]  age;
      logic [15:0] weight;
      logic [11:0] height;
      logic [31:0] tstamp;
   } rec_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SEARCH,
      S_SEARCH_CHK,
      S_SHIFT,
      S_SHIFT_WR,
      S_CLEAR,
      S_SCAN,
      S_SCAN_CHK,
      S_FETCH,
      S_FETCH_WAIT,
      S_OUT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic             latch_req;
      logic             rd_en;
      logic [IdxW-1:0]  rd_addr;
      logic             wr_en;
      logic [IdxW-1:0]  wr_addr;
      logic             wr_sel_req;   // 1: write request record, 0: write read data
      logic             wr_zero;
      logic             load_out;
      logic             out_from_mem;
      logic [2:0]       out_status;
      logic [IdxW-1:0]  out_pos;
      logic             out_last;
   } cmd_ctl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [31:0]  rd_key;
      logic [31:0]  rd_time;
      logic [31:0]  req_key;
      cmd_type      req_cmd;
   } dp_stat_type;

endpackage

>>> hdl/krt_datapath.sv
// Record memory, request register and result register of the keyed record table.
module krt_datapath (
   input  logic                 clock,
   input  krt_pkg::cmd_ctl_type ctl,
   input  krt_pkg::cmd_type     req_cmd,
   input  krt_pkg::rec_type     req_rec,
   output krt_pkg::dp_stat_type stat,
   output krt_pkg::rec_type     out_rec_ff,
   output logic [2:0]           out_status_ff,
   output logic [krt_pkg::IdxW-1:0] out_pos_ff,
   output logic                 out_last_ff
);
   import krt_pkg::*;

   rec_type mem [Capacity];
   rec_type rd_ff;
   rec_type req_ff;
   cmd_type cmd_ff;
   rec_type wr_data;
   rec_type out_rec_in;

   always_comb begin
      if (ctl.wr_zero) begin
         wr_data = '0;
      end else if (ctl.wr_sel_req) begin
         wr_data = req_ff;
      end else begin
         wr_data = rd_ff;
      end
   end

   // Error results carry only the request key; the empty dump carries nothing.
   always_comb begin
      out_rec_in = '0;
      if (ctl.out_from_mem) begin
         out_rec_in = rd_ff;
      end else if (ctl.out_status != ST_EMPTY) begin
         out_rec_in.key = req_ff.key;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_ff <= mem[ctl.rd_addr];
      end
      if (ctl.latch_req) begin
         req_ff <= req_rec;
         cmd_ff <= req_cmd;
      end
      if (ctl.load_out) begin
         out_status_ff <= ctl.out_status;
         out_pos_ff    <= ctl.out_pos;
         out_last_ff   <= ctl.out_last;
         out_rec_ff    <= out_rec_in;
      end
   end

   assign stat.rd_key  = rd_ff.key;
   assign stat.rd_time = rd_ff.tstamp;
   assign stat.req_key = req_ff.key;
   assign stat.req_cmd = cmd_ff;

endmodule

>>> hdl/krt_control.sv
// Command sequencer of the keyed record table: search, shift, sorted scan and output.
module krt_control (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  krt_pkg::dp_stat_type stat,
   output krt_pkg::cmd_ctl_type ctl
);
   import krt_pkg::*;

   state_type state_ff, state_in;
   logic [CntW-1:0] fill_ff, fill_in;
   logic [CntW-1:0] i_ff, i_in;        // walk index
   logic [CntW-1:0] rank_ff, rank_in;  // records emitted in a dump
   logic [IdxW-1:0] hit_ff, hit_in;    // found index
   logic [2:0]      st_ff, st_in;      // outcome of the current command
   // Dump: the previous emitted (time, index) and the current best candidate.
   logic [31:0] prev_t_ff, prev_t_in;
   logic [IdxW-1:0] prev_i_ff, prev_i_in;
   logic            have_prev_ff, have_prev_in;
   logic [31:0] best_t_ff, best_t_in;
   logic [IdxW-1:0] best_i_ff, best_i_in;
   logic            have_best_ff, have_best_in;
   logic            rsp_valid_ff, rsp_valid_in;

   logic [IdxW-1:0] i_lo, i_prev;
   logic            after_prev, better, key_hit, shift_end, dump_more;

   assign i_lo   = i_ff[IdxW-1:0];
   assign i_prev = IdxW'(i_ff - CntW'(1));
   // Stable order key (time, index): candidate must come strictly after prev.
   assign after_prev = !have_prev_ff || (stat.rd_time > prev_t_ff) ||
                       ((stat.rd_time == prev_t_ff) && (i_prev > prev_i_ff));
   assign better    = !have_best_ff || (stat.rd_time < best_t_ff);
   assign key_hit   = (stat.rd_key == stat.req_key);
   assign shift_end = (i_ff + CntW'(1) >= fill_ff);
   assign dump_more = (stat.req_cmd == CMD_DUMP) && (st_ff == ST_OK) &&
                      (rank_ff + CntW'(1) != fill_ff);

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff         <= i_in;
      rank_ff      <= rank_in;
      hit_ff       <= hit_in;
      st_ff        <= st_in;
      prev_t_ff    <= prev_t_in;
      prev_i_ff    <= prev_i_in;
      have_prev_ff <= have_prev_in;
      best_t_ff    <= best_t_in;
      best_i_ff    <= best_i_in;
      have_best_ff <= have_best_in;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            priority if (stat.req_cmd == CMD_DUMP) begin
               state_in = (fill_ff == '0) ? S_OUT : S_SCAN;
            end else if (stat.req_cmd == CMD_INSERT && fill_ff == CntW'(Capacity)) begin
               state_in = S_OUT;
            end else if (i_ff == fill_ff) begin
               state_in = (stat.req_cmd == CMD_INSERT) ? S_SHIFT_WR : S_OUT;
            end else begin
               state_in = S_SEARCH_CHK;
            end
         end
         S_SEARCH_CHK: begin
            if (key_hit) begin
               state_in = S_OUT;
            end else begin
               state_in = S_SEARCH;
            end
         end
         S_SHIFT_WR: state_in = S_FETCH;
         S_SHIFT: begin
            if (shift_end) begin
               state_in = S_CLEAR;
            end else begin
               state_in = S_SHIFT;
            end
         end
         S_CLEAR: state_in = S_IDLE;
         S_SCAN: begin
            if (i_ff == fill_ff) begin
               state_in = S_FETCH;
            end else begin
               state_in = S_SCAN_CHK;
            end
         end
         S_SCAN_CHK: state_in = S_SCAN;
         S_FETCH: state_in = S_FETCH_WAIT;
         S_FETCH_WAIT: state_in = S_OUT;
         S_OUT: begin
            if (rsp_valid_ff && !rsp_stall) begin
               priority if (dump_more) begin
                  state_in = S_SCAN;
               end else if (stat.req_cmd == CMD_REMOVE && st_ff == ST_OK) begin
                  state_in = S_SHIFT;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs and datapath registers.
   always_comb begin
      ctl          = '0;
      fill_in      = fill_ff;
      i_in         = i_ff;
      rank_in      = rank_ff;
      hit_in       = hit_ff;
      st_in        = st_ff;
      prev_t_in    = prev_t_ff;
      prev_i_in    = prev_i_ff;
      have_prev_in = have_prev_ff;
      best_t_in    = best_t_ff;
      best_i_in    = best_i_ff;
      have_best_in = have_best_ff;
      rsp_valid_in = rsp_valid_ff;
      ctl.rd_addr  = i_lo;
      ctl.wr_addr  = i_lo;
      unique case (state_ff)
         S_IDLE: begin
            ctl.latch_req = req_valid;
            i_in          = '0;
            rank_in       = '0;
            have_prev_in  = 1'b0;
            have_best_in  = 1'b0;
            hit_in        = '0;
         end
         S_SEARCH: begin
            priority if (stat.req_cmd == CMD_DUMP) begin
               st_in = (fill_ff == '0) ? ST_EMPTY : ST_OK;
            end else if (stat.req_cmd == CMD_INSERT && fill_ff == CntW'(Capacity)) begin
               st_in = ST_FULL;
            end else if (i_ff == fill_ff) begin
               st_in = (stat.req_cmd == CMD_INSERT) ? ST_OK : ST_NOT_FOUND;
            end else begin
               ctl.rd_en = 1'b1;
               i_in      = i_ff + CntW'(1);
            end
         end
         S_SEARCH_CHK: begin
            if (key_hit) begin
               hit_in = i_prev;
               st_in  = (stat.req_cmd == CMD_INSERT) ? ST_DUPLICATE : ST_OK;
            end
         end
         S_SHIFT_WR: begin
            ctl.wr_en      = 1'b1;
            ctl.wr_sel_req = 1'b1;
            ctl.wr_addr    = fill_ff[IdxW-1:0];
            hit_in         = fill_ff[IdxW-1:0];
            fill_in        = fill_ff + CntW'(1);
         end
         S_SHIFT: begin
            // i_ff walks from hit; entry i arrived in the read register last cycle.
            if (i_ff != CntW'(hit_ff)) begin
               ctl.wr_en   = 1'b1;
               ctl.wr_addr = i_prev;
            end
            if (!shift_end) begin
               ctl.rd_en   = 1'b1;
               ctl.rd_addr = IdxW'(i_ff + CntW'(1));
               i_in        = i_ff + CntW'(1);
            end
         end
         S_CLEAR: begin
            ctl.wr_en   = 1'b1;
            ctl.wr_zero = 1'b1;
            ctl.wr_addr = IdxW'(fill_ff - CntW'(1));
            fill_in     = fill_ff - CntW'(1);
         end
         S_SCAN: begin
            if (i_ff != fill_ff) begin
               ctl.rd_en = 1'b1;
               i_in      = i_ff + CntW'(1);
            end
         end
         S_SCAN_CHK: begin
            if (after_prev && better) begin
               best_t_in    = stat.rd_time;
               best_i_in    = i_prev;
               have_best_in = 1'b1;
            end
         end
         S_FETCH: begin
            ctl.rd_en   = 1'b1;
            ctl.rd_addr = (stat.req_cmd == CMD_DUMP) ? best_i_ff : hit_ff;
         end
         S_FETCH_WAIT: ;
         S_OUT: begin
            if (!rsp_valid_ff) begin
               ctl.load_out   = 1'b1;
               rsp_valid_in   = 1'b1;
               ctl.out_status = st_ff;
               ctl.out_last   = 1'b1;
               if (st_ff == ST_OK) begin
                  ctl.out_from_mem = 1'b1;
                  if (stat.req_cmd == CMD_DUMP) begin
                     ctl.out_pos  = rank_ff[IdxW-1:0];
                     ctl.out_last = (rank_ff + CntW'(1) == fill_ff);
                  end else begin
                     ctl.out_pos = hit_ff;
                  end
               end
            end else if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (dump_more) begin
                  rank_in      = rank_ff + CntW'(1);
                  prev_t_in    = best_t_ff;
                  prev_i_in    = best_i_ff;
                  have_prev_in = 1'b1;
                  have_best_in = 1'b0;
                  i_in         = '0;
               end else begin
                  i_in = CntW'(hit_ff);
               end
            end
         end
         default: ;
      endcase
   end

endmodule

>>> hdl/keyed_record_table_with_time_sort.sv
// Top level of the keyed record table with a time-sorted readout.
// The table holds up to 64 records packed in one memory in insertion order. It
// handles one command at a time and stalls its request side until the command
// has finished. Lookup walks the stored keys one entry at a time; insert, unless
// the table is full, does the same walk, then writes the new record and reads it
// back. Remove does the same search and then shifts every later record down by
// one, one entry per cycle, and then clears the vacated entry. A dump finds each
// next record by a full scan of the stored records for the smallest timestamp
// after the last one sent (ties in stored order), so each result costs one scan
// through the single memory read port. Each command ends with its last result
// held in an output register until it is taken.
module keyed_record_table_with_time_sort (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic signed [31:0] req_key_id,
   input  logic [7:0]  req_age,
   input  logic [15:0] req_weight_centikg,
   input  logic [11:0] req_height_mm,
   input  logic [31:0] req_admit_time,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic signed [31:0] rsp_rec_id,
   output logic [7:0]  rsp_rec_age,
   output logic [15:0] rsp_rec_weight,
   output logic [11:0] rsp_rec_height,
   output logic [31:0] rsp_rec_time,
   output logic [5:0]  rsp_position,
   output logic        rsp_last
);
   import krt_pkg::*;

   cmd_ctl_type ctl;
   dp_stat_type stat;
   rec_type     in_rec;
   rec_type     out_rec;
   logic [IdxW-1:0] out_pos;

   assign in_rec.key    = req_key_id;
   assign in_rec.age    = req_age;
   assign in_rec.weight = req_weight_centikg;
   assign in_rec.height = req_height_mm;
   assign in_rec.tstamp = req_admit_time;

   krt_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .ctl       (ctl)
   );

   krt_datapath u_datapath (
      .clock         (clock),
      .ctl           (ctl),
      .req_cmd       (cmd_type'(req_cmd)),
      .req_rec       (in_rec),
      .stat          (stat),
      .out_rec_ff    (out_rec),
      .out_status_ff (rsp_status),
      .out_pos_ff    (out_pos),
      .out_last_ff   (rsp_last)
   );

   assign rsp_rec_id     = out_rec.key;
   assign rsp_rec_age    = out_rec.age;
   assign rsp_rec_weight = out_rec.weight;
   assign rsp_rec_height = out_rec.height;
   assign rsp_rec_time   = out_rec.tstamp;
   assign rsp_position   = 6'(out_pos);

endmodule

>>> test/tb_keyed_record_table_with_time_sort.sv
// Testbench for the keyed record table: directed table, random commands, scoreboard.
`timescale 1ns / 1ps

module tb_keyed_record_table_with_time_sort;
   import krt_pkg::*;

   localparam int CycleLimit = 3000000;
   localparam int NumRandom = 248;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] id;
      logic [7:0]  age;
      logic [15:0] weight;
      logic [11:0] height;
      logic [31:0] tstamp;
      logic [5:0]  pos;
      logic        last;
   } rsp_type;

   // One row of the directed table. When has_exp is set, the typed-in result
   // is also compared with what the predictor computes for that row.
   typedef struct {
      cmd_type     cmd;
      logic [31:0] key;
      logic [7:0]  age;
      logic [15:0] weight;
      logic [11:0] height;
      logic [31:0] tstamp;
      bit          has_exp;
      rsp_type     exp;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_cmd = '0;
   logic signed [31:0] req_key_id = '0;
   logic [7:0] req_age = '0;
   logic [15:0] req_weight_centikg = '0;
   logic [11:0] req_height_mm = '0;
   logic [31:0] req_admit_time = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [2:0] rsp_status;
   logic signed [31:0] rsp_rec_id;
   logic [7:0] rsp_rec_age;
   logic [15:0] rsp_rec_weight;
   logic [11:0] rsp_rec_height;
   logic [31:0] rsp_rec_time;
   logic [5:0] rsp_position;
   logic rsp_last;

   keyed_record_table_with_time_sort uut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // The predictor's own copy of the table, packed in insertion order.
   rec_type table_rec[$];
   rsp_type pending_rsp[$];
   int mismatch_count = 0;
   int rsp_count = 0;
   int cycle_count = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int hold_off_cycles = 0;
   int dump_count = 0;
   int full_count = 0;

   function automatic rsp_type error_rsp(logic [2:0] st, logic [31:0] key);
      rsp_type r;
      r = '0;
      r.status = st;
      r.id = key;
      r.last = 1'b1;
      return r;
   endfunction

   function automatic rsp_type record_rsp(rec_type rec, int pos, bit fin);
      rsp_type r;
      r.status = ST_OK;
      r.id = rec.key;
      r.age = rec.age;
      r.weight = rec.weight;
      r.height = rec.height;
      r.tstamp = rec.tstamp;
      r.pos = pos[5:0];
      r.last = fin;
      return r;
   endfunction

   // Applies one command to the predicted table and queues the results it causes.
   task automatic predict_table_cmd(row_type row);
      int idx;
      int order[$];
      int j;
      rec_type rec;
      idx = -1;
      foreach (table_rec[i])
         if (idx < 0 && table_rec[i].key == row.key) idx = i;
      case (row.cmd)
         CMD_INSERT: begin
            if (table_rec.size() >= Capacity) begin
               pending_rsp.push_back(error_rsp(ST_FULL, row.key));
               full_count++;
            end else if (idx >= 0) begin
               pending_rsp.push_back(error_rsp(ST_DUPLICATE, row.key));
            end else begin
               rec = '{row.key, row.age, row.weight, row.height, row.tstamp};
               table_rec.push_back(rec);
               pending_rsp.push_back(record_rsp(rec, table_rec.size() - 1, 1'b1));
            end
         end
         CMD_LOOKUP, CMD_REMOVE: begin
            if (idx < 0) begin
               pending_rsp.push_back(error_rsp(ST_NOT_FOUND, row.key));
            end else begin
               pending_rsp.push_back(record_rsp(table_rec[idx], idx, 1'b1));
               if (row.cmd == CMD_REMOVE) table_rec.delete(idx);
            end
         end
         default: begin
            dump_count++;
            if (table_rec.size() == 0) begin
               pending_rsp.push_back(error_rsp(ST_EMPTY, '0));
            end else begin
               // Stable insertion sort by timestamp: equal times keep stored order.
               foreach (table_rec[i]) begin
                  j = order.size();
                  while (j > 0 && table_rec[order[j-1]].tstamp > table_rec[i].tstamp) j--;
                  order.insert(j, i);
               end
               foreach (order[i])
                  pending_rsp.push_back(record_rsp(table_rec[order[i]], i,
                                                   i == order.size() - 1));
            end
         end
      endcase
   endtask

   // Offers one item, with a random gap first, and predicts it once accepted.
   // Valid stays high after acceptance unless a gap or a drain follows.
   task automatic send_item(row_type row);
      int n;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= row.cmd;
      req_key_id <= row.key;
      req_age <= row.age;
      req_weight_centikg <= row.weight;
      req_height_mm <= row.height;
      req_admit_time <= row.tstamp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      n = pending_rsp.size();
      predict_table_cmd(row);
      if (row.has_exp && row.exp != pending_rsp[n]) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("table row disagrees with prediction: expected %h predicted %h",
                     row.exp, pending_rsp[n]);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   function automatic row_type make_row(cmd_type c, logic [31:0] k, logic [31:0] t);
      row_type r;
      r.cmd = c;
      r.key = k;
      r.age = $urandom;
      r.weight = $urandom;
      r.height = $urandom;
      r.tstamp = t;
      r.has_exp = 1'b0;
      r.exp = '0;
      return r;
   endfunction

   // Random command biased toward keys that are live or drawn from a small range.
   function automatic row_type random_row(int fill_bias);
      row_type r;
      int pick;
      logic [31:0] k;
      pick = $urandom_range(99);
      if (table_rec.size() > 0 && $urandom_range(2) != 0)
         k = table_rec[$urandom_range(table_rec.size() - 1)].key;
      else if ($urandom_range(3) == 0)
         k = $urandom;
      else
         k = $urandom_range(40);
      if (pick < fill_bias) r = make_row(CMD_INSERT, k, $urandom_range(15));
      else if (pick < fill_bias + 15) r = make_row(CMD_LOOKUP, k, 0);
      else if (pick < 95) r = make_row(CMD_REMOVE, k, 0);
      else r = make_row(CMD_DUMP, k, 0);
      // Wide timestamps now and then so every bit toggles; small ones make ties.
      if ($urandom_range(3) == 0) r.tstamp = $urandom;
      r.cmd = cmd_type'(pick < fill_bias ? CMD_INSERT : r.cmd);
      return r;
   endfunction

   // Result checker: compares every accepted result with the oldest expectation.
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_count++;
         got = '{rsp_status, rsp_rec_id, rsp_rec_age, rsp_rec_weight, rsp_rec_height,
                 rsp_rec_time, rsp_position, rsp_last};
         if (pending_rsp.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result %h", got);
         end else begin
            want = pending_rsp.pop_front();
            if (got != want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected st=%0d id=%h age=%h w=%h h=%h t=%h pos=%0d last=%b / got st=%0d id=%h age=%h w=%h h=%h t=%h pos=%0d last=%b",
                           want.status, want.id, want.age, want.weight, want.height,
                           want.tstamp, want.pos, want.last, got.status, got.id, got.age,
                           got.weight, got.height, got.tstamp, got.pos, got.last);
            end
         end
      end
   end

   // Receiver stall: random, or a long hold-off counted here in cycles.
   always @(posedge clock) begin
      if (hold_off_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_off_cycles <= hold_off_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("timeout with %0d results pending", pending_rsp.size());
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      row_type rows[$];
      row_type r;
      int phase;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table: empty-table cases, extremes, ties, duplicates, remove shift.
      r = make_row(CMD_DUMP, 0, 0);
      r.has_exp = 1; r.exp = error_rsp(ST_EMPTY, '0); rows.push_back(r);
      r = make_row(CMD_LOOKUP, 32'h8000_0000, 0);
      r.has_exp = 1; r.exp = error_rsp(ST_NOT_FOUND, 32'h8000_0000); rows.push_back(r);
      r = make_row(CMD_REMOVE, 32'h7FFF_FFFF, 0);
      r.has_exp = 1; r.exp = error_rsp(ST_NOT_FOUND, 32'h7FFF_FFFF); rows.push_back(r);
      r = make_row(CMD_INSERT, 32'h8000_0000, 32'hFFFF_FFFF);
      r.age = 8'hFF; r.weight = 16'hFFFF; r.height = 12'hFFF;
      r.has_exp = 1;
      r.exp = '{ST_OK, 32'h8000_0000, 8'hFF, 16'hFFFF, 12'hFFF, 32'hFFFF_FFFF, 6'd0, 1'b1};
      rows.push_back(r);
      r = make_row(CMD_INSERT, 32'h7FFF_FFFF, 0);
      r.age = 0; r.weight = 0; r.height = 0;
      r.has_exp = 1; r.exp = '{ST_OK, 32'h7FFF_FFFF, 8'h0, 16'h0, 12'h0, 32'h0, 6'd1, 1'b1};
      rows.push_back(r);
      r = make_row(CMD_INSERT, 32'h8000_0000, 5);
      r.has_exp = 1; r.exp = error_rsp(ST_DUPLICATE, 32'h8000_0000); rows.push_back(r);
      rows.push_back(make_row(CMD_INSERT, 0, 7));
      rows.push_back(make_row(CMD_INSERT, 32'hFFFF_FFFF, 7));
      rows.push_back(make_row(CMD_INSERT, 5, 7));
      rows.push_back(make_row(CMD_INSERT, 6, 3));
      rows.push_back(make_row(CMD_DUMP, 0, 0));
      rows.push_back(make_row(CMD_LOOKUP, 5, 0));
      rows.push_back(make_row(CMD_REMOVE, 0, 0));
      rows.push_back(make_row(CMD_LOOKUP, 5, 0));
      rows.push_back(make_row(CMD_REMOVE, 32'h8000_0000, 0));
      rows.push_back(make_row(CMD_REMOVE, 6, 0));
      rows.push_back(make_row(CMD_DUMP, 0, 0));
      rows.push_back(make_row(CMD_LOOKUP, 0, 0));
      foreach (rows[i]) send_item(rows[i]);

      // Fill the table to capacity, hit the full case, dump the full table.
      wait_drained();
      for (int k = 0; table_rec.size() < Capacity; k++)
         send_item(make_row(CMD_INSERT, 1000 + k, $urandom_range(20)));
      r = make_row(CMD_INSERT, 32'h7FFF_FFFF, 0);
      r.has_exp = 1; r.exp = error_rsp(ST_FULL, 32'h7FFF_FFFF);
      send_item(r);
      send_item(make_row(CMD_DUMP, 0, 0));
      send_item(make_row(CMD_REMOVE, 1000, 0));
      send_item(make_row(CMD_LOOKUP, 1063, 0));

      // Random phases with different idling; the sender pauses to drain between.
      for (phase = 0; phase < 4; phase++) begin
         wait_drained();
         case (phase)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 76; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 76; end
            default: begin sender_idle_pct = 9; receiver_stall_pct = 9; end
         endcase
         // Long receiver hold-off while items keep coming, so input backs up.
         if (phase == 0) hold_off_cycles = 2000;
         for (int k = 0; k < NumRandom / 4; k++)
            send_item(random_row(table_rec.size() < 20 ? 60 : 40));
      end

      wait_drained();
      $display("Covered %0d results, %0d dumps, %0d full rejects, over four idle phases.",
               rsp_count, dump_count, full_count);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("FAIL");
      end
      $finish;
   end

endmodule

>>> keyed_record_table_with_time_sort.f
hdl/krt_pkg.sv
hdl/krt_datapath.sv
hdl/krt_control.sv
hdl/keyed_record_table_with_time_sort.sv
test/tb_keyed_record_table_with_time_sort.sv
